// ===== hw/rtl/ilie_pkg.sv =====
// ----------------------------------------------------------------------------
// ilie_pkg: shared types and constants for the indexed list block
// Operation and status codes, field widths, the controller state type and
// the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ilie_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int KIND_W   = 3;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DROP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} ctrl_state_t;

	typedef struct packed {
		logic load;   // capture the request fields
		logic exec;   // commit the operation and load the result register
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ilie_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilie_ctrl: request sequencer
// Takes a request, then executes it once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ilie_pkg::dp_cmd_t     cmd
);
	import ilie_pkg::*;

	ctrl_state_t state_q;
	logic        out_valid_q;
	logic        slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.exec = (state_q == S_EXEC) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.exec) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ilie_dp.sv =====
// ----------------------------------------------------------------------------
// ilie_dp: list datapath
// Request registers, a row of entry cells that all shift up or down together,
// the entry count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilie_dp #(
	parameter int CAPACITY = ilie_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ilie_pkg::dp_cmd_t             cmd,
	input  wire logic [ilie_pkg::KIND_W-1:0]   kind,
	input  wire logic [ilie_pkg::POS_W-1:0]    position,
	input  wire logic signed [ilie_pkg::WORD_W-1:0] value,
	output logic [ilie_pkg::STATUS_W-1:0]      status,
	output logic signed [ilie_pkg::WORD_W-1:0] read_value,
	output logic [ilie_pkg::COUNT_W-1:0]       count
);
	import ilie_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [KIND_W-1:0]   kind_q;
	logic [POS_W-1:0]    pos_q;
	logic [WORD_W-1:0]   value_q;
	logic [WORD_W-1:0]   entries_q [CAPACITY];
	logic [CW-1:0]       used_q;

	logic [STATUS_W-1:0] status_q;
	logic [WORD_W-1:0]   read_value_q;
	logic [COUNT_W-1:0]  count_q;

	logic [PW-1:0]       pos_w;
	logic [PW-1:0]       n_w;
	logic [IW-1:0]       rd_idx;
	logic                full;
	logic [CW-1:0]       used_nxt;
	logic [STATUS_W-1:0] status_nxt;
	logic [WORD_W-1:0]   rd_nxt;
	logic                wr_app;
	logic                shift_up;
	logic                shift_dn;

	assign pos_w  = PW'(pos_q);
	assign n_w    = PW'(used_q);
	assign rd_idx = pos_w[IW-1:0];
	assign full   = (n_w >= PW'(CAPACITY));

	always_comb begin
		used_nxt   = used_q;
		status_nxt = ST_OK;
		rd_nxt     = '0;
		wr_app     = 1'b0;
		shift_up   = 1'b0;
		shift_dn   = 1'b0;
		unique case (kind_q)
			KIND_APPEND: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					wr_app   = 1'b1;
					used_nxt = CW'(used_q + 1'b1);
				end
			end
			KIND_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else if (pos_w > n_w) begin
					status_nxt = ST_RANGE;
					rd_nxt     = '1;
				end else begin
					shift_up = 1'b1;
					used_nxt = CW'(used_q + 1'b1);
				end
			end
			KIND_ERASE: begin
				if (pos_w >= n_w) begin
					status_nxt = ST_RANGE;
					rd_nxt     = '1;
				end else begin
					shift_dn = 1'b1;
					used_nxt = CW'(used_q - 1'b1);
				end
			end
			KIND_DROP: begin
				if (used_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					used_nxt = CW'(used_q - 1'b1);
				end
			end
			KIND_READ: begin
				if (pos_w >= n_w) begin
					status_nxt = ST_RANGE;
					rd_nxt     = '1;
				end else begin
					rd_nxt = entries_q[rd_idx];
				end
			end
			default: begin
			end
		endcase
	end

	// Entry cells: each one loads the new word or a neighbor's word.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] below;
		logic [WORD_W-1:0] above;
		if (i > 0) begin : g_below
			assign below = entries_q[i-1];
		end else begin : g_no_below
			assign below = '0;
		end
		if (i < CAPACITY - 1) begin : g_above
			assign above = entries_q[i+1];
		end else begin : g_no_above
			assign above = '0;
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (wr_app && (n_w == PW'(i))) begin
					entries_q[i] <= value_q;
				end else if (shift_up && (pos_w == PW'(i))) begin
					entries_q[i] <= value_q;
				end else if (shift_up && (pos_w < PW'(i))) begin
					entries_q[i] <= below;
				end else if (shift_dn && (pos_w <= PW'(i)) && (i < CAPACITY - 1)) begin
					entries_q[i] <= above;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.exec) begin
			used_q <= used_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			pos_q   <= position;
			value_q <= value;
		end
		if (cmd.exec) begin
			status_q     <= status_nxt;
			read_value_q <= rd_nxt;
			count_q      <= COUNT_W'(used_nxt);
		end
	end

	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_insert_erase.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_erase: bounded ordered list of signed 32-bit words
// Append, insert, erase, drop-last and read on a list held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: kind, position and
//   value. Output channel (out_valid/out_ready) returns one result per request:
//   status, read_value and the entry count after the request.
//   A transferred request is held in the request registers; the execute
//   state then loads its result into the result register once it is free.
//   A new request is taken only after the held one has executed; the request
//   register and the execute step of the single cell row set this.
//   Insert and erase shift every later entry in the same cycle; the entry
//   cells load from their neighbors, so no operation iterates.
//   Stall: while out_ready is low the finished result holds in its register;
//   one further request is still taken and waits in the execute state until
//   the result register frees up.
//   Reset (arst_n low): the list empties, out_valid drops and in_ready rises.
//   Entry contents are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_erase #(
	parameter int CAPACITY = ilie_pkg::CAPACITY_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [ilie_pkg::KIND_W-1:0]        kind,
	input  wire logic [ilie_pkg::POS_W-1:0]         position,
	input  wire logic signed [ilie_pkg::WORD_W-1:0] value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [ilie_pkg::STATUS_W-1:0]           status,
	output logic signed [ilie_pkg::WORD_W-1:0]      read_value,
	output logic [ilie_pkg::COUNT_W-1:0]            count
);
	import ilie_pkg::*;

	// Command bundle: load the request, then execute it into the result.
	dp_cmd_t cmd;

	// Sequencer: owns both handshakes.
	ilie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Datapath: cells, count and result register.
	ilie_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

endmodule

`default_nettype wire

// ===== verif/ilie_list_checker.sv =====
// ----------------------------------------------------------------------------
// ilie_list_checker: reply predictor and scoreboard for the indexed list
// Watches both channels of the block. Each request transfer is applied to a
// private copy of the list, and the expected reply is queued. Each reply
// transfer is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module ilie_list_checker #(
	parameter int CAPACITY = ilie_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [ilie_pkg::KIND_W-1:0]         kind,
	input  logic [ilie_pkg::POS_W-1:0]          position,
	input  logic signed [ilie_pkg::WORD_W-1:0]  value,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [ilie_pkg::STATUS_W-1:0]       status,
	input  logic signed [ilie_pkg::WORD_W-1:0]  read_value,
	input  logic [ilie_pkg::COUNT_W-1:0]        count,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked,
	output int                                  n_full,
	output int                                  n_range,
	output int                                  n_empty
);
	import ilie_pkg::*;

	localparam int MAX_PRINTED = 40;
	localparam int REPLY_DEPTH = 64;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   word;
		logic [COUNT_W-1:0]  len;
	} list_reply_t;

	// Expected replies in a ring: written at exp_tail, read at exp_head.
	list_reply_t       expected_replies [REPLY_DEPTH];
	int                exp_head = 0;
	int                exp_tail = 0;
	int                exp_count = 0;
	logic [WORD_W-1:0] shadow_words [CAPACITY];
	int unsigned       shadow_len = 0;

	int err_cnt = 0;
	int pend_cnt = 0;
	int reply_cnt = 0;
	int full_cnt = 0;
	int range_cnt = 0;
	int empty_cnt = 0;

	assign errors  = err_cnt;
	assign pending = pend_cnt;
	assign checked = reply_cnt;
	assign n_full  = full_cnt;
	assign n_range = range_cnt;
	assign n_empty = empty_cnt;

	task automatic report_mismatch(input string msg);
		if (err_cnt < MAX_PRINTED) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		err_cnt++;
	endtask

	// Apply one request to the shadow list and return the reply it earns.
	function automatic list_reply_t commit_request(
		input logic [KIND_W-1:0] k,
		input logic [POS_W-1:0]  p,
		input logic [WORD_W-1:0] w
	);
		list_reply_t r;
		int unsigned n;
		int          i;
		r.status = ST_OK;
		r.word   = '0;
		n        = shadow_len;
		case (k)
			KIND_APPEND: begin
				if (n >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_words[n] = w;
					n++;
				end
			end
			KIND_INSERT: begin
				if (n >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (p > n) begin
					r.status = ST_RANGE;
					r.word   = '1;
				end else begin
					for (i = n; i > int'(p); i--) begin
						shadow_words[i] = shadow_words[i-1];
					end
					shadow_words[p] = w;
					n++;
				end
			end
			KIND_ERASE: begin
				if (p >= n) begin
					r.status = ST_RANGE;
					r.word   = '1;
				end else begin
					for (i = int'(p) + 1; i < int'(n); i++) begin
						shadow_words[i-1] = shadow_words[i];
					end
					n--;
				end
			end
			KIND_DROP: begin
				if (n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					n--;
				end
			end
			KIND_READ: begin
				if (p >= n) begin
					r.status = ST_RANGE;
					r.word   = '1;
				end else begin
					r.word = shadow_words[p];
				end
			end
			default: ;
		endcase
		shadow_len = n;
		r.len      = COUNT_W'(n);
		return r;
	endfunction

	// All channel signals change only at the rising edge, so the falling edge
	// sees what the next rising edge will transfer.
	always @(negedge clk) begin : sample
		list_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_count == 0) begin
					report_mismatch($sformatf("reply with nothing expected (status %0d)", status));
				end else begin
					want      = expected_replies[exp_head];
					exp_head  = (exp_head + 1) % REPLY_DEPTH;
					exp_count = exp_count - 1;
					reply_cnt++;
					case (want.status)
						ST_FULL:  full_cnt++;
						ST_RANGE: range_cnt++;
						ST_EMPTY: empty_cnt++;
						default:  ;
					endcase
					if (status !== want.status) begin
						report_mismatch($sformatf("reply %0d status %0d, expected %0d",
							reply_cnt, status, want.status));
					end
					if (read_value !== $signed(want.word)) begin
						report_mismatch($sformatf("reply %0d read_value %0d, expected %0d",
							reply_cnt, read_value, $signed(want.word)));
					end
					if (count !== want.len) begin
						report_mismatch($sformatf("reply %0d count %0d, expected %0d",
							reply_cnt, count, want.len));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (exp_count == REPLY_DEPTH) begin
					report_mismatch("too many replies outstanding");
				end else begin
					expected_replies[exp_tail] = commit_request(kind, position, value);
					exp_tail  = (exp_tail + 1) % REPLY_DEPTH;
					exp_count = exp_count + 1;
				end
			end
			pend_cnt = exp_count;
		end
	end

endmodule

// ===== verif/indexed_list_insert_erase_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_tb: request traffic and verdict for the list block
// Runs a short directed sequence over the edge cases, then rounds of random
// requests biased to fill, drain, mix or probe with junk codes. Both channels
// idle at random; one long receiver hold backs the block up. The checker
// beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_tb;
	import ilie_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int ITEM_TARGET = 1400;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_ROUND  = 8;
	localparam int DRAIN_WAIT  = 8;
	localparam int CYCLE_LIMIT = 600000;

	// Kind codes the block must treat as no operation.
	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_MID   = 3'd6;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX,
		MODE_NOISE
	} traffic_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [KIND_W-1:0]         kind;
	logic [POS_W-1:0]          position;
	logic signed [WORD_W-1:0]  value;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic signed [WORD_W-1:0]  read_value;
	logic [COUNT_W-1:0]        count;

	int errors;
	int pending;
	int checked;
	int n_full;
	int n_range;
	int n_empty;

	int sent = 0;
	int cycles = 0;
	bit hold_out = 1'b0;

	always #6 clk = ~clk;

	indexed_list_insert_erase #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	ilie_list_checker #(
		.CAPACITY(CAPACITY)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.count      (count),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked),
		.n_full     (n_full),
		.n_range    (n_range),
		.n_empty    (n_empty)
	);

	// Give up if the run hangs: count every cycle and stop at the limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
			$display("[indexed_list_insert_erase] ERROR");
			$finish;
		end
	end

	// Receiver: alternate ready and stall stretches of random length, mostly
	// short, with a few long ready runs and a few long stalls. When hold_out
	// is raised, drop ready for the LONG_HOLD stretch so the block backs up.
	initial begin : receiver
		int  left;
		bit  level;
		left  = 0;
		level = 1'b0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				hold_out = 1'b0;
				level    = 1'b0;
				left     = LONG_HOLD;
			end else if (left == 0) begin
				if (!level) begin
					level = 1'b1;
					left  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					                                    : $urandom_range(1, 12);
				end else begin
					level = 1'b0;
					left  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					                                     : $urandom_range(15, 60);
				end
			end
			left--;
			out_ready <= level;
		end
	end

	// Offer one request and hold it until the transfer edge. Call only in the
	// time step of a rising edge; returns in the time step of the transfer.
	task automatic send_request(
		input logic [KIND_W-1:0]        k,
		input logic [POS_W-1:0]         p,
		input logic signed [WORD_W-1:0] v
	);
		in_valid <= 1'b1;
		kind     <= k;
		position <= p;
		value    <= v;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// Drop valid for the idle gap given by n; scramble the idle payload so the block must
	// ignore it.
	task automatic idle_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			kind     <= KIND_W'($urandom);
			position <= POS_W'($urandom);
			value    <= WORD_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold valid low until every expected reply has come back.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mostly random words, sometimes an extreme, zero or minus one.
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 39))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// Draw one request with the kind mix of the given mode and send it.
	task automatic send_random(input traffic_mode_t mode);
		logic [KIND_W-1:0] k;
		logic [POS_W-1:0]  p;
		int                r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				k = (r < 55) ? KIND_APPEND : (r < 85) ? KIND_INSERT :
				    (r < 92) ? KIND_READ   : (r < 96) ? KIND_ERASE  : KIND_DROP;
			end
			MODE_DRAIN: begin
				k = (r < 10) ? KIND_APPEND : (r < 20) ? KIND_INSERT :
				    (r < 50) ? KIND_ERASE  : (r < 80) ? KIND_DROP   : KIND_READ;
			end
			MODE_MIX: begin
				k = (r < 25) ? KIND_APPEND : (r < 45) ? KIND_INSERT :
				    (r < 65) ? KIND_ERASE  : (r < 75) ? KIND_DROP   : KIND_READ;
			end
			default: begin
				k = (r < 40) ? KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST))
				             : KIND_W'($urandom_range(KIND_APPEND, KIND_READ));
			end
		endcase
		// Keep most positions near the live range; let some reach the top bit.
		if (mode == MODE_NOISE || $urandom_range(0, 9) == 0) begin
			p = POS_W'($urandom_range(0, 31));
		end else begin
			p = POS_W'($urandom_range(0, CAPACITY));
		end
		send_request(k, p, pick_word());
	endtask

	initial begin : stimulus
		traffic_mode_t mode;
		int            round_len;
		int            rounds;
		bit            burst;

		// Drive every input to a known value from time zero.
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		kind     <= KIND_APPEND;
		position <= '0;
		value    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edge cases, back to back.
		send_request(KIND_DROP,   5'd0, 0);                // drop from empty list
		send_request(KIND_READ,   5'd0, 0);                // read on empty list
		send_request(KIND_ERASE,  5'd0, 0);                // erase on empty list
		send_request(KIND_INSERT, 5'd1, 5);                // insert past the end
		send_request(KIND_INSERT, 5'd0, 32'sh7FFF_FFFF);   // insert into empty list
		send_request(KIND_APPEND, 5'd0, 32'sh8000_0000);
		send_request(KIND_APPEND, 5'd0, 0);
		send_request(KIND_APPEND, 5'd0, -1);
		send_request(KIND_INSERT, 5'd4, 32'sh5A5A_5A5A);   // insert at the count
		send_request(KIND_INSERT, 5'd2, 32'sh1234_5678);   // insert in the middle
		send_request(KIND_READ,   5'd0, 0);
		send_request(KIND_READ,   5'd5, 0);
		send_request(KIND_READ,   5'd6, 0);                // read at the count
		send_request(KIND_READ,   5'd31, 0);               // read far past the end
		send_request(KIND_ERASE,  5'd0, 0);                // erase the head
		send_request(KIND_ERASE,  5'd4, 0);                // erase the tail
		send_request(KIND_ERASE,  5'd16, 0);               // erase past the end
		send_request(KIND_DROP,   5'd0, 0);
		send_request(KIND_UNUSED_FIRST, 5'd7, 32'sh0F0F_0F0F);
		send_request(KIND_UNUSED_MID,   5'd16, -1);
		send_request(KIND_UNUSED_LAST,  5'd31, 32'sh8000_0000);
		send_request(KIND_INSERT, 5'd31, 9);               // insert far past the end
		send_request(KIND_READ,   5'd1, 0);
		send_request(KIND_READ,   5'd2, 0);
		pause_until_drained();

		// Push toward capacity first so full-list cases come early.
		repeat (30) send_random(MODE_FILL);

		rounds = 0;
		while (sent < ITEM_TARGET) begin
			rounds++;
			mode      = traffic_mode_t'($urandom_range(MODE_FILL, MODE_NOISE));
			round_len = $urandom_range(20, 80);
			burst     = ($urandom_range(0, 3) == 0);
			if (rounds == HOLD_ROUND) begin
				// Stall the receiver and keep offering without gaps.
				hold_out  = 1'b1;
				burst     = 1'b1;
				round_len = 80;
			end
			repeat (round_len) begin
				send_random(mode);
				if (!burst) idle_sender(pick_gap());
			end
			if (rounds == HOLD_ROUND + 1 || $urandom_range(0, 4) == 0) begin
				pause_until_drained();
			end
		end

		// Let the last replies come home, then linger for stray ones.
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run: %0d requests in %0d rounds, %0d replies checked in %0d cycles",
			sent, rounds, checked, cycles);
		$display("replies seen: %0d full, %0d out of range, %0d empty; %0d mismatches",
			n_full, n_range, n_empty, errors);
		if (errors == 0 && pending == 0) begin
			$display("[indexed_list_insert_erase] OK");
		end else begin
			$display("[indexed_list_insert_erase] ERROR");
		end
		$finish;
	end

endmodule
